>>> rtl/mqcf_pkg.sv
package mqcf_pkg;

  localparam int NumQueues = 8;
  localparam int Depth = 16;
  localparam int DataWidth = 32;
  localparam int CmdDepth = 2;

  localparam int QidW = (NumQueues > 1) ? $clog2(NumQueues) : 1;
  localparam int SlotW = $clog2(Depth);
  localparam int CapW = $clog2(Depth + 1);
  localparam int SlotCount = NumQueues * Depth;
  localparam int AddrW = $clog2(SlotCount);
  localparam int CmdPtrW = $clog2(CmdDepth);
  localparam int CmdCntW = $clog2(CmdDepth + 1);

  typedef enum logic [2:0] {
    KIND_CREATE = 3'd0,
    KIND_DELETE = 3'd1,
    KIND_PUSH   = 3'd2,
    KIND_POP    = 3'd3,
    KIND_PEEK   = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EXISTS    = 3'd1,
    ST_NO_QUEUE  = 3'd2,
    ST_FULL      = 3'd3,
    ST_EMPTY     = 3'd4,
    ST_BAD_CAP   = 3'd5,
    ST_BAD_INDEX = 3'd6
  } status_e;

  typedef struct packed {
    logic [2:0]         kind;
    logic [2:0]         queue_id;
    logic signed [31:0] value;
    logic [4:0]         capacity;
    logic [3:0]         slot_index;
  } in_word_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] data;
    logic               data_valid;
  } out_word_t;

  typedef struct packed {
    status_e              status;
    logic                 rd;
    logic                 wr;
    logic                 zero;
    logic [AddrW-1:0]     addr;
    logic [DataWidth-1:0] wdata;
  } cmd_t;

  typedef struct packed {
    logic push;
    logic full;
  } cmd_wr_t;

  function automatic logic [SlotW-1:0] wrap_next(logic [SlotW-1:0] p, logic [CapW-1:0] cap);
    logic [CapW-1:0] inc;
    inc = CapW'(p) + CapW'(1);
    return (inc >= cap) ? '0 : SlotW'(inc);
  endfunction

  function automatic logic [AddrW-1:0] slot_addr(logic [QidW-1:0] q, logic [SlotW-1:0] s);
    return AddrW'(AddrW'(q) * AddrW'(Depth)) + AddrW'(s);
  endfunction

endpackage

>>> rtl/mqcf_front.sv
module mqcf_front import mqcf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  in_word_t in_word_i,
  input  logic     cmd_full_i,
  output cmd_wr_t  cmd_wr_o,
  output cmd_t     cmd_o
);

  logic [NumQueues-1:0] present_q, present_d;
  logic [NumQueues-1:0] empty_q, empty_d;
  logic [SlotW-1:0]     head_q [NumQueues];
  logic [SlotW-1:0]     head_d [NumQueues];
  logic [SlotW-1:0]     tail_q [NumQueues];
  logic [SlotW-1:0]     tail_d [NumQueues];
  logic [CapW-1:0]      cap_q [NumQueues];
  logic [CapW-1:0]      cap_d [NumQueues];
  logic [SlotCount-1:0] written_q, written_d;

  logic             accept;
  logic [QidW-1:0]  qi;
  logic             in_range;
  logic             present;
  logic [SlotW-1:0] head_cur;
  logic [SlotW-1:0] tail_cur;
  logic [CapW-1:0]  cap_cur;
  logic [SlotW-1:0] tail_nxt;
  logic [AddrW-1:0] addr;
  cmd_t             cmd;

  assign accept   = push_i && !cmd_full_i;
  assign qi       = QidW'(in_word_i.queue_id);
  assign in_range = int'(in_word_i.queue_id) < NumQueues;
  assign present  = in_range && present_q[qi];
  assign head_cur = head_q[qi];
  assign tail_cur = tail_q[qi];
  assign cap_cur  = cap_q[qi];
  assign tail_nxt = wrap_next(tail_cur, cap_cur);

  always_comb begin
    present_d = present_q;
    empty_d   = empty_q;
    head_d    = head_q;
    tail_d    = tail_q;
    cap_d     = cap_q;
    written_d = written_q;
    addr      = '0;
    cmd       = '{status: ST_OK, rd: 1'b0, wr: 1'b0, zero: 1'b0, addr: '0,
                  wdata: DataWidth'(in_word_i.value)};
    if (accept) begin
      case (kind_e'(in_word_i.kind))
        KIND_CREATE: begin
          if (present) begin
            cmd.status = ST_EXISTS;
          end else if (!in_range) begin
            cmd.status = ST_NO_QUEUE;
          end else if (in_word_i.capacity == '0 || int'(in_word_i.capacity) > Depth) begin
            cmd.status = ST_BAD_CAP;
          end else begin
            present_d[qi] = 1'b1;
            empty_d[qi]   = 1'b1;
            head_d[qi]    = '0;
            tail_d[qi]    = '0;
            cap_d[qi]     = CapW'(in_word_i.capacity);
            for (int s = 0; s < Depth; s++) begin
              written_d[slot_addr(qi, SlotW'(s))] = 1'b0;
            end
          end
        end
        KIND_DELETE: begin
          if (!present) begin
            cmd.status = ST_NO_QUEUE;
          end else begin
            present_d[qi] = 1'b0;
            empty_d[qi]   = 1'b1;
            head_d[qi]    = '0;
            tail_d[qi]    = '0;
          end
        end
        KIND_PUSH: begin
          if (!present) begin
            cmd.status = ST_NO_QUEUE;
          end else if (empty_q[qi]) begin
            addr            = slot_addr(qi, '0);
            head_d[qi]      = '0;
            tail_d[qi]      = '0;
            empty_d[qi]     = 1'b0;
            written_d[addr] = 1'b1;
            cmd.wr          = 1'b1;
            cmd.addr        = addr;
          end else if (tail_nxt == head_cur) begin
            cmd.status = ST_FULL;
          end else begin
            addr            = slot_addr(qi, tail_nxt);
            tail_d[qi]      = tail_nxt;
            written_d[addr] = 1'b1;
            cmd.wr          = 1'b1;
            cmd.addr        = addr;
          end
        end
        KIND_POP: begin
          if (!present) begin
            cmd.status = ST_NO_QUEUE;
          end else if (empty_q[qi]) begin
            cmd.status = ST_EMPTY;
          end else begin
            addr     = slot_addr(qi, head_cur);
            cmd.rd   = 1'b1;
            cmd.zero = !written_q[addr];
            cmd.addr = addr;
            if (head_cur == tail_cur) begin
              empty_d[qi] = 1'b1;
              head_d[qi]  = '0;
              tail_d[qi]  = '0;
            end else begin
              head_d[qi] = wrap_next(head_cur, cap_cur);
            end
          end
        end
        KIND_PEEK: begin
          if (!present) begin
            cmd.status = ST_NO_QUEUE;
          end else if (int'(in_word_i.slot_index) >= int'(cap_cur)) begin
            cmd.status = ST_BAD_INDEX;
          end else begin
            addr     = slot_addr(qi, SlotW'(in_word_i.slot_index));
            cmd.rd   = 1'b1;
            cmd.zero = !written_q[addr];
            cmd.addr = addr;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= '0;
      empty_q   <= '1;
      written_q <= '0;
      for (int i = 0; i < NumQueues; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        cap_q[i]  <= '0;
      end
    end else begin
      present_q <= present_d;
      empty_q   <= empty_d;
      written_q <= written_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      cap_q     <= cap_d;
    end
  end

  assign cmd_wr_o.push = accept;
  assign cmd_wr_o.full = cmd_full_i;
  assign cmd_o         = cmd;

`ifndef ASSERT_OFF
  a_no_rd_and_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> !(cmd.rd && cmd.wr))
    else $error("Command both reads and writes the slot store.");

  a_create_sets_present: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_word_i.kind == KIND_CREATE && cmd.status == ST_OK
    |=> present_q[$past(qi)] && empty_q[$past(qi)])
    else $error("Successful create did not leave the queue present and empty.");
`endif

endmodule

>>> rtl/mqcf_cmd_fifo.sv
module mqcf_cmd_fifo import mqcf_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  cmd_t  cmd_i,
  output logic  full_o,
  output logic  valid_o,
  input  logic  pop_i,
  output cmd_t  cmd_o
);

  cmd_t               mem_q [CmdDepth];
  logic [CmdPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [CmdPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CmdCntW-1:0] count_q, count_d;
  logic               do_push;
  logic               do_pop;

  assign full_o  = count_q == CmdCntW'(CmdDepth);
  assign valid_o = count_q != '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (int'(wr_ptr_q) == CmdDepth - 1) ? '0 : wr_ptr_q + CmdPtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (int'(rd_ptr_q) == CmdDepth - 1) ? '0 : rd_ptr_q + CmdPtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CmdCntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CmdCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(count_q) <= CmdDepth)
    else $error("Command queue count exceeds its depth.");
`endif

endmodule

>>> rtl/mqcf_back.sv
module mqcf_back import mqcf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  input  cmd_t      cmd_i,
  output logic      cmd_pop_o,
  output logic      empty_o,
  input  logic      pop_i,
  output out_word_t out_word_o
);

  logic [DataWidth-1:0] slot_mem_q [SlotCount];
  logic [DataWidth-1:0] rd_q;
  logic                 out_valid_q, out_valid_d;
  status_e              status_q;
  logic                 dvalid_q;
  logic                 zero_q;
  logic                 take;

  assign take      = cmd_valid_i && (!out_valid_q || pop_i);
  assign cmd_pop_o = take;

  always_comb begin
    out_valid_d = out_valid_q;
    if (take) begin
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      status_q <= cmd_i.status;
      dvalid_q <= cmd_i.rd;
      zero_q   <= cmd_i.zero;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && cmd_i.wr) begin
      slot_mem_q[cmd_i.addr] <= cmd_i.wdata;
    end
    if (take && cmd_i.rd) begin
      rd_q <= slot_mem_q[cmd_i.addr];
    end
  end

  assign empty_o               = !out_valid_q;
  assign out_word_o.status     = status_q;
  assign out_word_o.data_valid = dvalid_q;
  assign out_word_o.data       = (dvalid_q && !zero_q) ? 32'(rd_q) : '0;

`ifndef ASSERT_OFF
  a_data_needs_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && dvalid_q |-> status_q == ST_OK)
    else $error("Word carries data with a failing status.");

  a_held_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !pop_i |=> out_valid_q && $stable(out_word_o))
    else $error("Pending result changed while stalled.");
`endif

endmodule

>>> rtl/multi_queue_circular_fifo.sv
// Manager for eight small circular queues of up to sixteen words each, addressed by queue id.
// Each input word is one operation (create, delete, push, pop or peek) and yields exactly one
// result word with a status and, for pop and peek, the data read. The front end checks every
// operation against the per-queue pointers in the cycle it is accepted and hands a command to a
// two-entry queue; the back end performs the slot store access and holds the result in an
// output register. One operation is accepted per cycle when results are drained; the single-port
// slot store, one access per cycle, sets that rate. A result passes through the command queue and
// then the output register before it is offered.
module multi_queue_circular_fifo import mqcf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  in_word_t  in_word_i,
  output logic      empty,
  input  logic      pop,
  output out_word_t out_word_o
);

  cmd_wr_t cmd_wr;
  cmd_t    front_cmd;
  cmd_t    back_cmd;
  logic    cmd_full;
  logic    cmd_valid;
  logic    cmd_pop;

  mqcf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .in_word_i  (in_word_i),
    .cmd_full_i (cmd_full),
    .cmd_wr_o   (cmd_wr),
    .cmd_o      (front_cmd)
  );

  mqcf_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_wr.push),
    .cmd_i   (front_cmd),
    .full_o  (cmd_full),
    .valid_o (cmd_valid),
    .pop_i   (cmd_pop),
    .cmd_o   (back_cmd)
  );

  mqcf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (back_cmd),
    .cmd_pop_o   (cmd_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .out_word_o  (out_word_o)
  );

  assign full = cmd_wr.full;

endmodule
